// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define FPA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds outside reset.
`define FPA_ASSERT_NEVER(label, clk, rst_n, cond) \
  `FPA_ASSERT(label, clk, rst_n, !(cond))

`endif

// ===== hdl/fpa_pkg.sv =====
package fpa_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 8;
  // Quotient bits resolved in each divider stage; the last stage may resolve fewer.
  localparam int DIV_STEPS     = 4;
  // Wide enough for the rounded product magnitude and the rounded quotient.
  localparam int MAG_BITS      = 2 * WORD_BITS + 1;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_MIN = 3'd4,
    MODE_MAX = 3'd5,
    MODE_INC = 3'd6,
    MODE_DEC = 3'd7
  } fpa_mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } fpa_status_e;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [2:0] mode;
    word_t      operand_a;
    word_t      operand_b;
  } fpa_in_t;

  typedef struct packed {
    word_t      result_value;
    logic       less_flag;
    logic       equal_flag;
    logic       greater_flag;
    logic [1:0] status;
  } fpa_out_t;

  typedef struct packed {
    fpa_mode_e            mode;
    logic                 neg;
    logic [WORD_BITS-1:0] ma;
    logic [WORD_BITS-1:0] mb;
    logic                 lt;
    logic                 eq;
    logic                 gt;
    word_t                simple_res;
    fpa_status_e          simple_st;
  } fpa_s1_t;

  typedef struct packed {
    fpa_mode_e              mode;
    logic                   neg;
    logic                   lt;
    logic                   eq;
    logic                   gt;
    word_t                  simple_res;
    fpa_status_e            simple_st;
    logic [2*WORD_BITS-1:0] prod;
  } fpa_side_t;

  typedef struct packed {
    word_t value;
    logic  ovf;
  } fpa_sat_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Gives a magnitude its sign, saturating when it leaves the signed range.
  function automatic fpa_sat_t sat_mag(input logic [MAG_BITS-1:0] mag, input logic neg);
    logic [MAG_BITS-1:0] lim;
    fpa_sat_t            r;
    lim = MAG_BITS'(1) << (WORD_BITS - 1);
    if (!neg) lim = lim - MAG_BITS'(1);
    if (mag > lim) begin
      r.ovf   = 1'b1;
      r.value = neg ? WORD_MIN : WORD_MAX;
    end else begin
      r.ovf   = 1'b0;
      r.value = neg ? (~mag[WORD_BITS-1:0] + 1'b1) : mag[WORD_BITS-1:0];
    end
    return r;
  endfunction

  // Saturating add or subtract of two signed words.
  function automatic fpa_sat_t add_sat(input word_t a, input word_t b, input logic sub);
    logic [WORD_BITS:0] s;
    fpa_sat_t           r;
    if (sub) s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    else     s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      r.ovf   = 1'b1;
      r.value = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      r.ovf   = 1'b0;
      r.value = s[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/fpa_div_stage.sv =====
module fpa_div_stage #(
  parameter int NUM_BITS = 40,
  parameter int STEPS    = 4
) (
  input  logic                           clk_i,
  input  logic [NUM_BITS-1:0]            nq_i,
  input  logic [fpa_pkg::WORD_BITS-1:0]  rem_i,
  input  logic [fpa_pkg::WORD_BITS-1:0]  den_i,
  output logic [NUM_BITS-1:0]            nq_o,
  output logic [fpa_pkg::WORD_BITS-1:0]  rem_o,
  output logic [fpa_pkg::WORD_BITS-1:0]  den_o
);

  localparam int W = fpa_pkg::WORD_BITS;

  // The dividend shifts out at the top while quotient bits shift in below.
  logic [NUM_BITS-1:0] nq_d, nq_q;
  logic [W-1:0]        rem_d, rem_q, den_q;

  always_comb begin
    logic [W:0] r2;
    logic [W:0] diff;
    logic       ge;
    nq_d  = nq_i;
    rem_d = rem_i;
    for (int s = 0; s < STEPS; s++) begin
      r2    = {rem_d, nq_d[NUM_BITS-1]};
      diff  = r2 - {1'b0, den_i};
      ge    = (r2 >= {1'b0, den_i});
      rem_d = ge ? diff[W-1:0] : r2[W-1:0];
      nq_d  = {nq_d[NUM_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_i;
  end

  assign nq_o  = nq_q;
  assign rem_o = rem_q;
  assign den_o = den_q;

endmodule

// ===== hdl/fpa_divider.sv =====
module fpa_divider #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic [fpa_pkg::WORD_BITS+FRAC_BITS-1:0]  num_i,
  input  logic [fpa_pkg::WORD_BITS-1:0]            den_i,
  output logic [fpa_pkg::WORD_BITS+FRAC_BITS-1:0]  quot_o,
  output logic [fpa_pkg::WORD_BITS-1:0]            rem_o,
  output logic [fpa_pkg::WORD_BITS-1:0]            den_o
);

  localparam int W  = fpa_pkg::WORD_BITS;
  localparam int N  = W + FRAC_BITS;
  localparam int SP = fpa_pkg::DIV_STEPS;
  localparam int NS = (N + SP - 1) / SP;

  logic [N-1:0] nq  [NS+1];
  logic [W-1:0] rem [NS+1];
  logic [W-1:0] den [NS+1];

  assign nq[0]  = num_i;
  assign rem[0] = '0;
  assign den[0] = den_i;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int LEFT  = N - k * SP;
    localparam int STEPS = (LEFT < SP) ? LEFT : SP;
    fpa_div_stage #(
      .NUM_BITS (N),
      .STEPS    (STEPS)
    ) u_stage (
      .clk_i (clk_i),
      .nq_i  (nq[k]),
      .rem_i (rem[k]),
      .den_i (den[k]),
      .nq_o  (nq[k+1]),
      .rem_o (rem[k+1]),
      .den_o (den[k+1])
    );
  end

  assign quot_o = nq[NS];
  assign rem_o  = rem[NS];
  assign den_o  = den[NS];

endmodule

// ===== hdl/fixed_point_alu_q24_8.sv =====
// Channel   Ports                      Handshake
// input     start_i, item_i            taken when start_i is high and busy_o is low
// output    done_o, result_o           held for one cycle while done_o is high
//
// One item can be taken in every cycle; busy_o never rises. Each item passes through
// the stage-one register, the divider stages and the output register. The divider
// resolves up to four quotient bits per pipeline stage. Reset clears the valid bits
// of the pipeline, so no item is in flight after it; the receiver cannot stall.
module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  fpa_pkg::fpa_in_t item_i,
  output logic             done_o,
  output fpa_pkg::fpa_out_t result_o
);

  localparam int W  = fpa_pkg::WORD_BITS;
  localparam int N  = W + FRAC_BITS;
  localparam int MB = fpa_pkg::MAG_BITS;
  localparam int NS = (N + fpa_pkg::DIV_STEPS - 1) / fpa_pkg::DIV_STEPS;
  localparam logic [MB-1:0] RND = MB'(1) << (FRAC_BITS - 1);

  // The pipeline never holds items back.
  assign busy_o = 1'b0;

  // Stage one: operand magnitudes, comparison flags, and the results of all
  // modes that need no multiplier or divider.
  fpa_pkg::fpa_s1_t s1_d, s1_q;
  logic             v1_q;

  always_comb begin
    fpa_pkg::word_t   a;
    fpa_pkg::word_t   b;
    fpa_pkg::fpa_sat_t sr;
    a = item_i.operand_a;
    b = item_i.operand_b;
    s1_d.mode = fpa_pkg::fpa_mode_e'(item_i.mode);
    s1_d.neg  = a[W-1] ^ b[W-1];
    s1_d.ma   = a[W-1] ? (~a + 1'b1) : a;
    s1_d.mb   = b[W-1] ? (~b + 1'b1) : b;
    s1_d.lt   = $signed(a) < $signed(b);
    s1_d.gt   = $signed(a) > $signed(b);
    s1_d.eq   = (a == b);
    sr.value  = '0;
    sr.ovf    = 1'b0;
    case (s1_d.mode)
      fpa_pkg::MODE_ADD: sr = fpa_pkg::add_sat(a, b, 1'b0);
      fpa_pkg::MODE_SUB: sr = fpa_pkg::add_sat(a, b, 1'b1);
      fpa_pkg::MODE_INC: sr = fpa_pkg::add_sat(a, fpa_pkg::word_t'(1), 1'b0);
      fpa_pkg::MODE_DEC: sr = fpa_pkg::add_sat(a, fpa_pkg::word_t'(1), 1'b1);
      fpa_pkg::MODE_MIN: sr.value = s1_d.gt ? b : a;
      fpa_pkg::MODE_MAX: sr.value = s1_d.gt ? a : b;
      default: sr.value = '0;
    endcase
    s1_d.simple_res = sr.value;
    s1_d.simple_st  = sr.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // Side line: it runs next to the divider stages and carries everything the
  // final stage needs. Its first register also catches the product.
  fpa_pkg::fpa_side_t side_q [NS];
  fpa_pkg::fpa_side_t side_d;
  logic [NS-1:0]      vld_q;

  always_comb begin
    side_d.mode       = s1_q.mode;
    side_d.neg        = s1_q.neg;
    side_d.lt         = s1_q.lt;
    side_d.eq         = s1_q.eq;
    side_d.gt         = s1_q.gt;
    side_d.simple_res = s1_q.simple_res;
    side_d.simple_st  = s1_q.simple_st;
    side_d.prod       = s1_q.ma * s1_q.mb;
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int k = 1; k < NS; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], v1_q};
    end
  end

  // Divider on the magnitudes, dividend scaled up by the fraction bits.
  logic [N-1:0] quot;
  logic [W-1:0] rem, den;

  fpa_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .num_i  ({s1_q.ma, {FRAC_BITS{1'b0}}}),
    .den_i  (s1_q.mb),
    .quot_o (quot),
    .rem_o  (rem),
    .den_o  (den)
  );

  // Final stage: rounding half away from zero, sign, saturation, selection.
  fpa_pkg::fpa_out_t out_d, out_q;
  logic              done_q;

  always_comb begin
    fpa_pkg::fpa_side_t l;
    logic [MB-1:0]      pr;
    logic [MB-1:0]      dmag;
    logic               rnd;
    fpa_pkg::fpa_sat_t  ms;
    fpa_pkg::fpa_sat_t  ds;
    l    = side_q[NS-1];
    pr   = ({1'b0, l.prod} + RND) >> FRAC_BITS;
    rnd  = ({rem, 1'b0} >= {1'b0, den});
    dmag = MB'(quot) + MB'(rnd);
    ms   = fpa_pkg::sat_mag(pr, l.neg);
    ds   = fpa_pkg::sat_mag(dmag, l.neg);
    out_d.less_flag    = l.lt;
    out_d.equal_flag   = l.eq;
    out_d.greater_flag = l.gt;
    case (l.mode)
      fpa_pkg::MODE_MUL: begin
        out_d.result_value = ms.value;
        out_d.status       = ms.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
      end
      fpa_pkg::MODE_DIV: begin
        if (den == '0) begin
          out_d.result_value = '0;
          out_d.status       = fpa_pkg::ST_DIV0;
        end else begin
          out_d.result_value = ds.value;
          out_d.status       = ds.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
        end
      end
      default: begin
        out_d.result_value = l.simple_res;
        out_d.status       = l.simple_st;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

// ===== hdl/fpa_checker.sv =====
`include "assert_macros.svh"

module fpa_checker #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input fpa_pkg::fpa_out_t result_o
);

  localparam int N   = fpa_pkg::WORD_BITS + FRAC_BITS;
  localparam int LAT = (N + fpa_pkg::DIV_STEPS - 1) / fpa_pkg::DIV_STEPS + 2;

  logic acc;
  assign acc = start_i && !busy_o;

  `FPA_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o)
  `FPA_ASSERT(a_done_has_item, clk_i, rst_ni, done_o |-> $past(acc, LAT))
  `FPA_ASSERT(a_item_gives_done, clk_i, rst_ni, acc |-> ##LAT done_o)
  `FPA_ASSERT(a_flags_onehot, clk_i, rst_ni,
    done_o |-> $onehot({result_o.less_flag, result_o.equal_flag, result_o.greater_flag}))
  `FPA_ASSERT(a_div0_zero, clk_i, rst_ni,
    (done_o && result_o.status == fpa_pkg::ST_DIV0) |-> (result_o.result_value == '0))

endmodule

bind fixed_point_alu_q24_8 fpa_checker #(.FRAC_BITS(FRAC_BITS)) u_fpa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);
